FILE: rtl/core/swm_pkg.sv
// Shared constants and codes for the stack with middle access.
package swm_pkg;

  // Storage size and derived widths
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream items
  localparam int CMD_W    = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP        = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ_MID   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE_MID = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: rtl/core/stack_with_middle_access.sv
// Stack of signed words with read and delete of the middle element.
//
// Input channel (s_axis_*): one command item per handshake, carrying the
// command (push, pop, read middle, delete middle) and the word to push.
// Output channel (m_axis_*): exactly one result item per command, with the
// popped, read or deleted word, a status (ok, empty, full) and the number of
// stored words after the command.
// The middle is the word at position (count-1)/2 counted from the bottom.
// The command is decoded and the register-array stack updated in the cycle
// it is accepted, and its result sits in the output register on the next
// edge. A new command can be accepted every cycle, set by the single output
// register: s_axis_tready is high while that register is empty or being
// drained in the same cycle.
// When the receiver stalls, the result is held and s_axis_tready stays low,
// so no further command is accepted until the result is taken.
// Reset empties the stack and the output register; stored words are not
// cleared, since a slot is always written before it is read.
module stack_with_middle_access (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [1:0] command, [33:2] push_value, [39:34] zero
  input  logic [swm_pkg::IN_W-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [31:0] result_value, [33:32] status, [38:34] depth_now, [39] zero
  output logic [swm_pkg::OUT_W-1:0] m_axis_tdata
);
  import swm_pkg::*;

  // Stack storage and fill count
  logic [WORD_W-1:0] store [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  // Output register
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_value;
  logic [STATUS_W-1:0]      out_status;
  logic [DEPTH_W-1:0]       out_depth;

  // Decoded item and datapath
  logic                     accept;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] push_word;
  logic [CNT_W-1:0]         count_m1;
  logic [IDX_W-1:0]         top_idx;
  logic [IDX_W-1:0]         mid_idx;
  logic                     is_empty;
  logic                     is_full;
  logic                     do_push;
  logic                     do_delete;
  logic signed [WORD_W-1:0] value_next;
  logic [STATUS_W-1:0]      status_next;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign cmd           = s_axis_tdata[CMD_W-1:0];
  assign push_word     = s_axis_tdata[CMD_W+WORD_W-1:CMD_W];

  // Top and middle positions
  assign count_m1 = count - CNT_W'(1);
  assign top_idx  = count_m1[IDX_W-1:0];
  assign mid_idx  = IDX_W'(count_m1 >> 1);
  assign is_empty = (count == '0);
  assign is_full  = (count >= CNT_W'(CAPACITY));

  // Command decode
  always_comb begin
    count_next  = count;
    value_next  = '0;
    status_next = ST_OK;
    do_push     = 1'b0;
    do_delete   = 1'b0;
    case (cmd)
      CMD_PUSH: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_push    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          value_next = store[top_idx];
          count_next = count_m1;
        end
      end
      CMD_READ_MID: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          value_next = store[mid_idx];
        end
      end
      CMD_DELETE_MID: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          value_next = store[mid_idx];
          do_delete  = 1'b1;
          count_next = count_m1;
        end
      end
      default: begin
        status_next = ST_EMPTY;
      end
    endcase
  end

  // Storage: push writes the slot above the top; delete shifts everything
  // from the middle up down by one place (slots above the top are don't care)
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_push && (count[IDX_W-1:0] == IDX_W'(i))) begin
          store[i] <= push_word;
        end else if (do_delete && (IDX_W'(i) >= mid_idx) && (i < CAPACITY - 1)) begin
          store[i] <= store[(i + 1) % CAPACITY];
        end
      end
    end
  end

  // Count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_value  <= value_next;
      out_status <= status_next;
      out_depth  <= DEPTH_W'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W - WORD_W - STATUS_W - DEPTH_W){1'b0}},
                          out_depth, out_status, out_value};

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("stack count beyond capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_PUSH && !is_full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("push did not grow the stack");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid && out_depth == DEPTH_W'(count)))
    else $error("result missing or depth mismatch after accepted item");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (accept && is_empty && cmd != CMD_PUSH) |=> (out_status == ST_EMPTY && out_value == '0))
    else $error("empty stack command gave wrong result");

endmodule
